// ===== hdl/tlcn_pkg.sv =====
// Package for the tile line color normalizer: mode codes, register indexes and color helpers.
package tlcn_pkg;

    // Pattern mode codes
    localparam logic [2:0] MODE_AUTO     = 3'd0;
    localparam logic [2:0] MODE_FORCE_FG = 3'd1;
    localparam logic [2:0] MODE_FORCE_BG = 3'd2;
    localparam logic [2:0] MODE_HIGH_FG  = 3'd3;
    localparam logic [2:0] MODE_LOW_FG   = 3'd4;
    localparam logic [2:0] MODE_LIGHT_FG = 3'd5;
    localparam logic [2:0] MODE_DARK_FG  = 3'd6;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCED_BIT           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFERRED_BACKGROUND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIPPED_IMAGE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FIRST          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LAST           = 3'd5;

    localparam int CFG_DATA_W = 17;

    localparam logic [7:0] PATTERN_EMPTY = 8'h00;
    localparam logic [7:0] PATTERN_FULL  = 8'hff;
    localparam logic [3:0] COLOR_WHITE   = 4'd15;
    localparam logic [CFG_DATA_W-1:0] RANGE_OPEN = '1;

    typedef struct packed {
        logic [7:0] pattern;
        logic [7:0] color;
    } tile_line_t;

    // Brightness rank of each palette color
    function automatic logic [3:0] bright_of(input logic [3:0] color);
        logic [3:0] rank;
        begin
            unique case (color)
                4'd0:  rank = 4'd0;
                4'd1:  rank = 4'd1;
                4'd2:  rank = 4'd5;
                4'd3:  rank = 4'd10;
                4'd4:  rank = 4'd2;
                4'd5:  rank = 4'd7;
                4'd6:  rank = 4'd3;
                4'd7:  rank = 4'd11;
                4'd8:  rank = 4'd6;
                4'd9:  rank = 4'd9;
                4'd10: rank = 4'd12;
                4'd11: rank = 4'd13;
                4'd12: rank = 4'd4;
                4'd13: rank = 4'd8;
                4'd14: rank = 4'd14;
                4'd15: rank = 4'd15;
                default: rank = 4'd0;
            endcase
            return rank;
        end
    endfunction

    // Complement the pattern and swap the color nibbles
    function automatic tile_line_t invert_line(input tile_line_t line);
        tile_line_t res;
        begin
            res.pattern = ~line.pattern;
            res.color   = {line.color[3:0], line.color[7:4]};
            return res;
        end
    endfunction

    // True when both lines show the same color at every pixel
    function automatic logic same_pixels(input tile_line_t a, input tile_line_t b);
        logic       same;
        logic [3:0] ca;
        logic [3:0] cb;
        begin
            same = 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                ca = a.pattern[i] ? a.color[7:4] : a.color[3:0];
                cb = b.pattern[i] ? b.color[7:4] : b.color[3:0];
                if (ca != cb)
                    same = 1'b0;
            end
            return same;
        end
    endfunction

endpackage

// ===== hdl/tile_line_color_normalizer.sv =====
// Tile line color normalizer: input register, normalize logic, output register.
//
// Takes one 8-pixel tile line per cycle unless m_tready stalls the output, and
// returns an equivalent pattern/color pair, possibly inverted, through the input
// register and then the result register. Throughput is set by the
// previous-line feedback: the line just decided is written into the previous-line
// register at the same edge that loads the result, so the next line sees it at
// once. Configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while no line is in flight.
module tile_line_color_normalizer
    import tlcn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [7:0] line_pattern, [15:8] line_color,
                                              // [31:16] line_index
    input  logic [0:0]             s_tuser,   // [0] frame_start
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata    // [7:0] out_pattern, [15:8] out_color
);

    // Configuration registers
    logic [2:0]            pattern_mode_reg;
    logic [2:0]            forced_bit_reg;
    logic [3:0]            preferred_bg_reg;
    logic                  stripped_image_reg;
    logic [CFG_DATA_W-1:0] range_first_reg;
    logic [CFG_DATA_W-1:0] range_last_reg;

    // Pipeline registers
    logic        in_valid_reg;
    tile_line_t  in_line_reg;
    logic [15:0] in_index_reg;
    logic        in_frame_start_reg;
    logic        out_valid_reg;
    tile_line_t  out_line_reg;
    tile_line_t  prev_line_reg;

    logic        out_free;
    logic        in_advance;
    tile_line_t  prev_line;
    tile_line_t  line_inv;
    tile_line_t  line_next;
    logic        in_range;
    logic        first_ok;
    logic        last_ok;
    logic [2:0]  mode;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic        single;
    logic [3:0]  single_color;
    logic        pb_dark;
    logic        forced_pix;
    logic [3:0]  rank_hi;
    logic [3:0]  rank_lo;

    assign cfg_ready = 1'b1;

    // Hold configuration, write on a completed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mode_reg   <= MODE_AUTO;
            forced_bit_reg     <= '0;
            preferred_bg_reg   <= '0;
            stripped_image_reg <= 1'b0;
            range_first_reg    <= RANGE_OPEN;
            range_last_reg     <= RANGE_OPEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_MODE:         pattern_mode_reg   <= cfg_data[2:0];
                REG_FORCED_BIT:           forced_bit_reg     <= cfg_data[2:0];
                REG_PREFERRED_BACKGROUND: preferred_bg_reg   <= cfg_data[3:0];
                REG_STRIPPED_IMAGE:       stripped_image_reg <= cfg_data[0];
                REG_RANGE_FIRST:          range_first_reg    <= cfg_data;
                REG_RANGE_LAST:           range_last_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the output register frees when its transaction completes
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || out_free;
    assign in_advance = in_valid_reg && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_line_reg.color, out_line_reg.pattern};

    // Previous line, reloaded at frame start
    always_comb
    begin
        if (in_frame_start_reg)
        begin
            prev_line.pattern = PATTERN_EMPTY;
            prev_line.color   = {preferred_bg_reg, preferred_bg_reg};
        end
        else
        begin
            prev_line = prev_line_reg;
        end
    end

    // Range check on the line index
    always_comb
    begin
        if (range_first_reg == RANGE_OPEN || range_first_reg[CFG_DATA_W-1])
            first_ok = 1'b1;
        else
            first_ok = range_first_reg[15:0] <= in_index_reg;
        if (range_last_reg == RANGE_OPEN)
            last_ok = 1'b1;
        else if (range_last_reg[CFG_DATA_W-1])
            last_ok = 1'b0;
        else
            last_ok = in_index_reg <= range_last_reg[15:0];
    end

    assign in_range = first_ok && last_ok;
    assign mode     = in_range ? pattern_mode_reg : MODE_AUTO;
    assign hi       = in_line_reg.color[7:4];
    assign lo       = in_line_reg.color[3:0];
    assign rank_hi  = bright_of(hi);
    assign rank_lo  = bright_of(lo);
    assign pb_dark  = bright_of(preferred_bg_reg) < 4'd8;
    assign line_inv = invert_line(in_line_reg);
    assign forced_pix = in_line_reg.pattern[forced_bit_reg];

    // Detect a single-color line
    always_comb
    begin
        single       = 1'b1;
        single_color = lo;
        if (in_line_reg.pattern == PATTERN_EMPTY)
            single_color = lo;
        else if (in_line_reg.pattern == PATTERN_FULL)
            single_color = hi;
        else if (lo != hi)
            single = 1'b0;
    end

    // Normalize the line
    always_comb
    begin
        line_next = in_line_reg;
        unique case (mode)
            MODE_FORCE_FG:
            begin
                if (!forced_pix)
                    line_next = line_inv;
            end
            MODE_FORCE_BG:
            begin
                if (forced_pix)
                    line_next = line_inv;
            end
            MODE_HIGH_FG:
            begin
                if (hi < lo || (in_line_reg.pattern == PATTERN_FULL && hi < 4'd2))
                    line_next = line_inv;
            end
            MODE_LOW_FG:
            begin
                if (lo < hi || (in_line_reg.pattern == PATTERN_EMPTY && lo == COLOR_WHITE))
                    line_next = line_inv;
            end
            MODE_LIGHT_FG:
            begin
                if (rank_hi < rank_lo)
                    line_next = line_inv;
            end
            MODE_DARK_FG:
            begin
                if (rank_lo < rank_hi)
                    line_next = line_inv;
            end
            default:
            begin
                // Automatic choice
                if (same_pixels(in_line_reg, prev_line))
                begin
                    line_next = prev_line;
                end
                else if (single)
                begin
                    if (stripped_image_reg)
                    begin
                        line_next.pattern = PATTERN_FULL;
                        line_next.color   = {single_color, preferred_bg_reg};
                    end
                    else if (single_color == prev_line.color[3:0])
                    begin
                        line_next.pattern = PATTERN_EMPTY;
                        line_next.color   = prev_line.color;
                    end
                    else if (single_color == prev_line.color[7:4])
                    begin
                        line_next.pattern = PATTERN_FULL;
                        line_next.color   = prev_line.color;
                    end
                    else if (pb_dark == (bright_of(single_color) < 4'd8))
                    begin
                        line_next.pattern = PATTERN_EMPTY;
                        line_next.color   = {4'd0, single_color};
                    end
                    else
                    begin
                        line_next.pattern = PATTERN_FULL;
                        line_next.color   = {single_color, preferred_bg_reg};
                    end
                end
                else if (in_line_reg.color == prev_line.color)
                begin
                    line_next = in_line_reg;
                end
                else if (line_inv.color == prev_line.color)
                begin
                    line_next = line_inv;
                end
                else if (lo == preferred_bg_reg)
                begin
                    line_next = in_line_reg;
                end
                else if (hi == preferred_bg_reg)
                begin
                    line_next = line_inv;
                end
                else if (pb_dark ? (rank_lo > rank_hi) : (rank_lo < rank_hi))
                begin
                    line_next = line_inv;
                end
            end
        endcase
    end

    // Advance the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_line_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (in_advance)
                prev_line_reg <= line_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_line_reg.pattern <= s_tdata[7:0];
            in_line_reg.color   <= s_tdata[15:8];
            in_index_reg        <= s_tdata[31:16];
            in_frame_start_reg  <= s_tuser[0];
        end
        if (in_advance)
            out_line_reg <= line_next;
    end

endmodule

// ===== test/tlcn_line_checker.sv =====
// Line checker for the tile line color normalizer: predicts each output line and compares it.
`timescale 1ns / 1ps

module tlcn_line_checker
    import tlcn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [7:0] line_pattern, [15:8] line_color,
                                              // [31:16] line_index
    input  logic [0:0]             s_tuser,   // [0] frame_start
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [15:0]            m_tdata,   // [7:0] out_pattern, [15:8] out_color
    output int                     fail_count,
    output int                     pending,
    output int                     lines_checked
);

    // Brightness rank per palette color, color 0 in the lowest nibble
    localparam logic [63:0] LUMA_RANKS = {4'd15, 4'd14, 4'd8, 4'd4, 4'd13, 4'd12, 4'd9, 4'd6,
                                          4'd11, 4'd3, 4'd7, 4'd2, 4'd10, 4'd5, 4'd1, 4'd0};

    // Local copy of the registers and of the previous output line
    logic [2:0]  cfg_mode;
    logic [2:0]  cfg_fbit;
    logic [3:0]  pref_bg;
    logic        strip;
    logic [16:0] range_lo;
    logic [16:0] range_hi;
    tile_line_t  last_line;

    tile_line_t  normalized_q[$];
    tile_line_t  oldest;
    tile_line_t  incoming;
    int          errs;
    int          checked;

    function automatic logic [3:0] luma(input logic [3:0] c);
        return LUMA_RANKS[{c, 2'b00} +: 4];
    endfunction

    function automatic tile_line_t flipped(input tile_line_t l);
        tile_line_t r;
        r.pattern = ~l.pattern;
        r.color   = {l.color[3:0], l.color[7:4]};
        return r;
    endfunction

    function automatic logic shows_same(input tile_line_t a, input tile_line_t b);
        logic same;
        same = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if ((a.pattern[i] ? a.color[7:4] : a.color[3:0]) !=
                (b.pattern[i] ? b.color[7:4] : b.color[3:0]))
                same = 1'b0;
        end
        return same;
    endfunction

    // Automatic choice: previous line first, then single-color lines, then preferred background, then brightness
    function automatic tile_line_t auto_pick(input tile_line_t l);
        tile_line_t r;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [3:0] sc;
        logic       one_color;
        logic       dark_pb;
        r  = l;
        fg = l.color[7:4];
        bg = l.color[3:0];
        sc = bg;
        one_color = 1'b1;
        if (l.pattern == PATTERN_EMPTY)
            sc = bg;
        else if (l.pattern == PATTERN_FULL)
            sc = fg;
        else if (fg == bg)
            sc = bg;
        else
            one_color = 1'b0;
        dark_pb = luma(pref_bg) < 4'd8;

        if (shows_same(l, last_line))
            r = last_line;
        else if (one_color)
        begin
            if (strip)
                r = {PATTERN_FULL, sc, pref_bg};
            else if (sc == last_line.color[3:0])
                r = {PATTERN_EMPTY, last_line.color};
            else if (sc == last_line.color[7:4])
                r = {PATTERN_FULL, last_line.color};
            else if (dark_pb == (luma(sc) < 4'd8))
                r = {PATTERN_EMPTY, 4'd0, sc};  // full background takes foreground 0
            else
                r = {PATTERN_FULL, sc, pref_bg};
        end
        else if (l.color == last_line.color)
            r = l;
        else if ({bg, fg} == last_line.color)
            r = flipped(l);
        else if (bg == pref_bg)
            r = l;
        else if (fg == pref_bg)
            r = flipped(l);
        else if (dark_pb ? (luma(bg) > luma(fg)) : (luma(bg) < luma(fg)))
            r = flipped(l);
        return r;
    endfunction

    function automatic tile_line_t normalize(input tile_line_t l, input logic [15:0] idx);
        tile_line_t r;
        logic [2:0] mode;
        logic [3:0] hi;
        logic [3:0] lo;
        logic       in_range;
        // a bound of all ones is absent; other negative bounds compare as signed
        in_range = (range_lo == RANGE_OPEN || int'($signed(range_lo)) <= int'(idx)) &&
                   (range_hi == RANGE_OPEN || int'($signed(range_hi)) >= int'(idx));
        mode = in_range ? cfg_mode : MODE_AUTO;
        hi = l.color[7:4];
        lo = l.color[3:0];
        r  = l;
        case (mode)
            MODE_FORCE_FG: if (!l.pattern[cfg_fbit]) r = flipped(l);
            MODE_FORCE_BG: if (l.pattern[cfg_fbit]) r = flipped(l);
            MODE_HIGH_FG:
                if (hi < lo || (l.pattern == PATTERN_FULL && hi < 4'd2))
                    r = flipped(l);
            MODE_LOW_FG:
                if (lo < hi || (l.pattern == PATTERN_EMPTY && lo == COLOR_WHITE))
                    r = flipped(l);
            MODE_LIGHT_FG: if (luma(hi) < luma(lo)) r = flipped(l);
            MODE_DARK_FG:  if (luma(lo) < luma(hi)) r = flipped(l);
            default:       r = auto_pick(l);
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode  = MODE_AUTO;
            cfg_fbit  = '0;
            pref_bg   = '0;
            strip     = 1'b0;
            range_lo  = RANGE_OPEN;
            range_hi  = RANGE_OPEN;
            last_line = '0;
            normalized_q.delete();
            errs      = 0;
            checked   = 0;
        end
        else
        begin
            // Mirror register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_MODE:         cfg_mode = cfg_data[2:0];
                    REG_FORCED_BIT:           cfg_fbit = cfg_data[2:0];
                    REG_PREFERRED_BACKGROUND: pref_bg  = cfg_data[3:0];
                    REG_STRIPPED_IMAGE:       strip    = cfg_data[0];
                    REG_RANGE_FIRST:          range_lo = cfg_data;
                    REG_RANGE_LAST:           range_hi = cfg_data;
                    default: ;
                endcase
            end

            // Retire an output transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (normalized_q.size() == 0)
                begin
                    $error("unexpected output line: pattern %02h color %02h",
                           m_tdata[7:0], m_tdata[15:8]);
                    errs++;
                end
                else
                begin
                    oldest = normalized_q.pop_front();
                    checked++;
                    if (m_tdata[7:0] !== oldest.pattern)
                    begin
                        $error("out_pattern: expected %02h, actual %02h",
                               oldest.pattern, m_tdata[7:0]);
                        errs++;
                    end
                    if (m_tdata[15:8] !== oldest.color)
                    begin
                        $error("out_color: expected %02h, actual %02h",
                               oldest.color, m_tdata[15:8]);
                        errs++;
                    end
                end
            end

            // Predict an input transaction; the prediction becomes the previous line
            if (s_tvalid && s_tready)
            begin
                incoming.pattern = s_tdata[7:0];
                incoming.color   = s_tdata[15:8];
                if (s_tuser[0])
                    last_line = {PATTERN_EMPTY, pref_bg, pref_bg};
                last_line = normalize(incoming, s_tdata[31:16]);
                normalized_q.push_back(last_line);
            end
        end
        fail_count    <= errs;
        pending       <= normalized_q.size();
        lines_checked <= checked;
    end

endmodule

// ===== test/tb_tile_line_color_normalizer.sv =====
// Testbench top for the tile line color normalizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_tile_line_color_normalizer;
    import tlcn_pkg::*;

    localparam logic [2:0]  MODE_SPARE       = 3'd7;
    localparam logic [16:0] BOUND_MINUS_FIVE = 17'h1fffb;
    localparam logic [16:0] BOUND_MINUS_TWO  = 17'h1fffe;
    localparam logic [16:0] BOUND_MOST_NEG   = 17'h10000;
    localparam logic [16:0] BOUND_TOP        = 17'h0ffff;
    localparam int          NUM_PHASES       = 19;
    localparam int          PHASE_LINES      = 50;
    localparam int          IDLE_PCT         = 36;
    localparam int          CYCLE_LIMIT      = 200000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;  // [7:0] line_pattern, [15:8] line_color,
                                             // [31:16] line_index
    logic [0:0]             s_tuser   = '0;  // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;         // [7:0] out_pattern, [15:8] out_color

    int          fail_count;
    int          pending;
    int          lines_checked;
    int          cycle_count;
    int          settings_done = 0;
    logic        no_idle = 1'b0;
    logic [3:0]  cur_pb  = '0;
    logic [16:0] cur_lo  = RANGE_OPEN;
    logic [16:0] cur_hi  = RANGE_OPEN;
    logic [7:0]  prev_pat = '0;
    logic [7:0]  prev_col = '0;

    tile_line_color_normalizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tlcn_line_checker line_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .lines_checked (lines_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output side at random
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    // Present one line and hold it until the transaction completes
    task automatic send_line(input logic [7:0] pat, input logic [7:0] col,
                             input logic [15:0] idx, input logic fs);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, col, pat};
        s_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_tready);
        prev_pat = pat;
        prev_col = col;
    endtask

    // Drop valid and wait until every line has come out
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write the full register set; only called with no line in flight
    task automatic configure(input logic [2:0] mode, input logic [2:0] fbit,
                             input logic [3:0] pb, input logic strip,
                             input logic [16:0] lo, input logic [16:0] hi);
        cfg_write(REG_PATTERN_MODE, CFG_DATA_W'(mode));
        cfg_write(REG_FORCED_BIT, CFG_DATA_W'(fbit));
        cfg_write(REG_PREFERRED_BACKGROUND, CFG_DATA_W'(pb));
        cfg_write(REG_STRIPPED_IMAGE, CFG_DATA_W'(strip));
        cfg_write(REG_RANGE_FIRST, lo);
        cfg_write(REG_RANGE_LAST, hi);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_pb = pb;
        cur_lo = lo;
        cur_hi = hi;
        settings_done++;
    endtask

    function automatic logic [16:0] pick_bound();
        logic [15:0] v;
        int          sel;
        v   = 16'($urandom);
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return RANGE_OPEN;
        else if (sel == 1)
            return {1'b1, v};
        else
            return {1'b0, v};
    endfunction

    // Random line, mostly tied to the previous line or the preferred background
    task automatic random_line(output logic [7:0] pat, output logic [7:0] col,
                               output logic [15:0] idx, output logic fs);
        int kind;
        kind = $urandom_range(0, 99);
        pat  = 8'($urandom);
        col  = 8'($urandom);
        if (kind < 20)
            col = prev_col;
        else if (kind < 32)
            col = {prev_col[3:0], prev_col[7:4]};
        else if (kind < 44)
        begin
            pat = ~prev_pat;
            col = {prev_col[3:0], prev_col[7:4]};
        end
        else if (kind < 54)
            pat = $urandom_range(0, 1) ? PATTERN_FULL : PATTERN_EMPTY;
        else if (kind < 60)
            col = {col[7:4], col[7:4]};
        else if (kind < 70)
            col = $urandom_range(0, 1) ? {col[7:4], cur_pb} : {cur_pb, col[3:0]};

        // Aim the index at the range bounds now and then
        case ($urandom_range(0, 9))
            0:       idx = 16'h0000;
            1:       idx = 16'hffff;
            2, 3:    idx = 16'(cur_lo[15:0] - 16'd1 + 16'($urandom_range(0, 2)));
            4, 5:    idx = 16'(cur_hi[15:0] - 16'd1 + 16'($urandom_range(0, 2)));
            default: idx = 16'($urandom);
        endcase
        fs = ($urandom_range(0, 19) == 0);
    endtask

    // Give up after a generous number of cycles
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d lines outstanding", cycle_count, pending);
        $display("tb_tile_line_color_normalizer: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  pat;
        logic [7:0]  col;
        logic [15:0] idx;
        logic        fs;
        int          m;

        // Hold reset, then release on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset defaults: auto mode, open range
        send_line(8'h00, 8'h00, 16'h0000, 1'b1);
        send_line(8'hff, 8'hff, 16'hffff, 1'b0);
        send_line(8'h5a, 8'h3c, 16'h0001, 1'b0);
        send_line(8'ha5, 8'hc3, 16'h0002, 1'b0);  // same pixels as the line before
        send_line(8'h0f, 8'h3c, 16'h0003, 1'b0);
        end_burst();

        // Forced foreground inside a narrow range, stripped handling outside it
        configure(MODE_FORCE_FG, 3'd7, COLOR_WHITE, 1'b1, 17'd10, 17'd20);
        send_line(8'h00, 8'h34, 16'd9, 1'b0);
        send_line(8'h7f, 8'h12, 16'd10, 1'b0);
        send_line(8'h80, 8'h12, 16'd20, 1'b0);
        send_line(8'h33, 8'h5f, 16'd21, 1'b1);
        end_burst();

        // Negative lower bound other than open admits every index
        configure(MODE_FORCE_BG, 3'd0, 4'd7, 1'b0, BOUND_MINUS_FIVE, RANGE_OPEN);
        send_line(8'h01, 8'h9a, 16'h0000, 1'b0);
        send_line(8'hfe, 8'h9a, 16'hffff, 1'b0);
        end_burst();

        // Negative upper bound other than open admits no index
        configure(MODE_HIGH_FG, 3'd0, 4'd0, 1'b0, RANGE_OPEN, BOUND_MINUS_TWO);
        send_line(8'hff, 8'h10, 16'h0000, 1'b0);
        end_burst();

        // Color order modes, their workarounds and the spare mode code
        for (m = int'(MODE_HIGH_FG); m <= int'(MODE_SPARE); m++)
        begin
            configure(m[2:0], 3'd3, 4'd1, 1'b0, RANGE_OPEN, RANGE_OPEN);
            send_line(8'hff, 8'h10, 16'h0100, 1'b0);
            send_line(8'h00, 8'hff, 16'h0101, 1'b0);
            send_line(8'h5a, 8'h2e, 16'h0102, 1'b0);
            end_burst();
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                configure(MODE_AUTO, 3'd0, 4'd0, 1'b0, BOUND_MOST_NEG, RANGE_OPEN);
            else if (ph == 1)
                configure(MODE_SPARE, 3'd7, COLOR_WHITE, 1'b1, BOUND_TOP, BOUND_TOP);
            else if (ph == 2)
                configure(MODE_DARK_FG, 3'd5, 4'd8, 1'b0, 17'd0, 17'd0);
            else
                configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          pick_bound(), pick_bound());
            no_idle = (ph >= 8 && ph <= 10);
            for (int n = 0; n < PHASE_LINES; n++)
            begin
                random_line(pat, col, idx, fs);
                send_line(pat, col, idx, fs);
            end
            end_burst();
        end
        no_idle = 1'b0;

        // Let any stray output show up
        repeat (8) @(posedge clk);
        if (pending != 0)
            $error("%0d expected output lines never arrived", pending);

        $display("Checked %0d output lines under %0d register settings.",
                 lines_checked, settings_done);
        $display("Covered every mode, open, negative and tight ranges, frame starts, stalls.");
        if (fail_count == 0 && pending == 0)
            $display("tb_tile_line_color_normalizer: done, clean");
        else
            $display("tb_tile_line_color_normalizer: done, errors");
        $finish;
    end

endmodule
